// ===== hdl/request_retry_backoff_controller_assert.svh =====
// Assertion macros for the retry/backoff controller checker.
// Both expect clk_i and rst_ni in scope.
`ifndef REQUEST_RETRY_BACKOFF_CONTROLLER_ASSERT_SVH
`define REQUEST_RETRY_BACKOFF_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define RRBC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rrbc assertion failed");

// next-cycle implication
`define RRBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rrbc assertion failed");

`endif

// ===== hdl/rrbc_pkg.sv =====
// Shared types and constants of the retry/backoff controller.
// No dependencies.
package rrbc_pkg;

  localparam int unsigned MaxBackoffMs = 10000;
  localparam logic [31:0] MaxBackoffW  = 32'(MaxBackoffMs);

  localparam int unsigned CountW  = 11;
  localparam int unsigned LimitW  = 10;
  localparam int unsigned CongW   = 5;
  localparam int unsigned DelayW  = 14;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [CfgIdxW-1:0] CfgMaxNack     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNackUnlim   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxTimeout  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgTimeoutUnlim = 2'd3;

  localparam logic [1:0] ReasonDuplicate  = 2'd0;
  localparam logic [1:0] ReasonCongestion = 2'd1;

  typedef enum logic [2:0] {
    KindStart   = 3'd0,
    KindData    = 3'd1,
    KindNack    = 3'd2,
    KindTimeout = 3'd3,
    KindBackoff = 3'd4,
    KindCancel  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ActIgnored     = 3'd0,
    ActDeliver     = 3'd1,
    ActResendNow   = 3'd2,
    ActResendLater = 3'd3,
    ActFailReason  = 3'd4,
    ActFailNack    = 3'd5,
    ActFailTimeout = 3'd6,
    ActCancelled   = 3'd7
  } action_e;

  typedef struct packed {
    logic [LimitW-1:0] max_nack;
    logic              nack_unlim;
    logic [LimitW-1:0] max_timeout;
    logic              timeout_unlim;
  } cfg_t;

  typedef struct packed {
    logic              stopped;
    logic              failed;
    logic [CountW-1:0] nack_count;
    logic [CountW-1:0] timeout_count;
    logic [CongW-1:0]  cong_count;
  } state_t;

endpackage

// ===== hdl/rrbc_step.sv =====
// Next-state and action logic for one event of the retry controller.
// Depends on rrbc_pkg.
module rrbc_step (
  input  rrbc_pkg::cfg_t                   cfg_i,
  input  rrbc_pkg::state_t                 state_i,
  input  logic [2:0]                       kind_i,
  input  logic [1:0]                       nack_reason_i,
  output rrbc_pkg::state_t                 state_o,
  output rrbc_pkg::action_e                action_o,
  output logic [rrbc_pkg::DelayW-1:0]      delay_ms_o
);
  import rrbc_pkg::*;

  logic [CountW-1:0] nack_inc, timeout_inc;
  logic              nack_ok, timeout_ok;
  logic [31:0]       pow;
  logic              capped;
  kind_e             kind;

  assign kind        = kind_e'(kind_i);
  assign nack_inc    = (state_i.nack_count != CountMax) ?
                       state_i.nack_count + 1'b1 : state_i.nack_count;
  assign timeout_inc = (state_i.timeout_count != CountMax) ?
                       state_i.timeout_count + 1'b1 : state_i.timeout_count;
  assign nack_ok     = cfg_i.nack_unlim || (nack_inc <= {1'b0, cfg_i.max_nack});
  assign timeout_ok  = cfg_i.timeout_unlim ||
                       (timeout_inc <= {1'b0, cfg_i.max_timeout});
  assign pow         = 32'd1 << state_i.cong_count;
  assign capped      = pow > MaxBackoffW;

  always_comb begin
    state_o    = state_i;
    action_o   = ActIgnored;
    delay_ms_o = '0;
    if (!state_i.stopped && !state_i.failed) begin
      unique case (kind) inside
        KindStart, KindBackoff: begin
          state_o.cong_count = '0;
          action_o           = ActResendNow;
        end
        KindData: begin
          state_o.stopped = 1'b1;
          action_o        = ActDeliver;
        end
        KindNack: begin
          if (!cfg_i.nack_unlim) state_o.nack_count = nack_inc;
          if (!nack_ok) begin
            state_o.failed = 1'b1;
            action_o       = ActFailNack;
          end else begin
            case (nack_reason_i)
              ReasonDuplicate: begin
                state_o.cong_count = '0;
                action_o           = ActResendNow;
              end
              ReasonCongestion: begin
                if (capped) begin
                  delay_ms_o = MaxBackoffW[DelayW-1:0];
                end else begin
                  delay_ms_o         = pow[DelayW-1:0];
                  state_o.cong_count = state_i.cong_count + 1'b1;
                end
                action_o = ActResendLater;
              end
              default: begin
                state_o.failed = 1'b1;
                action_o       = ActFailReason;
              end
            endcase
          end
        end
        KindTimeout: begin
          if (!cfg_i.timeout_unlim) state_o.timeout_count = timeout_inc;
          if (timeout_ok) begin
            state_o.cong_count = '0;
            action_o           = ActResendNow;
          end else begin
            state_o.failed = 1'b1;
            action_o       = ActFailTimeout;
          end
        end
        KindCancel: begin
          state_o.stopped = 1'b1;
          action_o        = ActCancelled;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/request_retry_backoff_controller.sv =====
// Top level of the retry controller with capped exponential backoff.
// Depends on rrbc_pkg and rrbc_step.
//
// Usage:
//   Events enter on the in channel (kind_i, nack_reason_i, valid/ready).
//   Each event yields one item on the out channel (action_o, delay_ms_o).
//   Output is registered: out_valid_o rises in the cycle after input accept.
//   Throughput: 1 item per cycle unless the receiver stalls; rrbc_step
//   updates the flags and counters in the same cycle the item is accepted.
//   The result register frees itself when the item is taken, so
//   in_ready_o is high while the result register is empty or being read.
//   Receiver stall: the result holds, in_ready_o drops, state is frozen.
//   Reset: flags and counts clear, limits return to 15 (not unlimited),
//   output goes invalid.
//   Configuration: cfg_we_i writes register cfg_index_i (0 max nack
//   retries, 1 nack unlimited, 2 max timeout retries, 3 timeout unlimited)
//   from cfg_wdata_i; write only while idle.
module request_retry_backoff_controller (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rrbc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rrbc_pkg::LimitW-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [2:0]                       kind_i,
  input  logic [1:0]                       nack_reason_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0]                       action_o,
  output logic [rrbc_pkg::DelayW-1:0]      delay_ms_o
);
  import rrbc_pkg::*;

  cfg_t              cfg_q;
  state_t            state_q, state_d;
  action_e           act_d;
  logic [DelayW-1:0] delay_d, delay_q;
  logic [2:0]        action_q;
  logic              out_valid_q;
  logic              accept;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign action_o    = action_q;
  assign delay_ms_o  = delay_q;

  rrbc_step u_step (
    .cfg_i         (cfg_q),
    .state_i       (state_q),
    .kind_i        (kind_i),
    .nack_reason_i (nack_reason_i),
    .state_o       (state_d),
    .action_o      (act_d),
    .delay_ms_o    (delay_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_nack      <= LimitW'(15);
      cfg_q.nack_unlim    <= 1'b0;
      cfg_q.max_timeout   <= LimitW'(15);
      cfg_q.timeout_unlim <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgMaxNack:      cfg_q.max_nack      <= cfg_wdata_i;
        CfgNackUnlim:    cfg_q.nack_unlim    <= cfg_wdata_i[0];
        CfgMaxTimeout:   cfg_q.max_timeout   <= cfg_wdata_i;
        CfgTimeoutUnlim: cfg_q.timeout_unlim <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= act_d;
      delay_q  <= delay_d;
    end
  end

endmodule

// ===== hdl/rrbc_checker.sv =====
// Port-level checker for the retry controller, bound to the top level.
// Depends on rrbc_pkg and request_retry_backoff_controller_assert.svh.
`include "request_retry_backoff_controller_assert.svh"

module rrbc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [2:0]                   action_o,
  input logic [rrbc_pkg::DelayW-1:0]  delay_ms_o
);
  import rrbc_pkg::*;

  logic out_take, terminal;

  assign out_take = out_valid_o && out_ready_i;
  assign terminal = (action_o == ActDeliver) || (action_o == ActCancelled) ||
                    (action_o == ActFailReason) || (action_o == ActFailNack) ||
                    (action_o == ActFailTimeout);

  `RRBC_ASSERT_NEXT(a_in_to_out, in_valid_i && in_ready_o, out_valid_o)
  `RRBC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(action_o) && $stable(delay_ms_o))
  `RRBC_ASSERT_NOW(a_delay_only_later, out_valid_o && action_o != ActResendLater, delay_ms_o == '0)
  `RRBC_ASSERT_NEXT(a_done_then_ignored, out_take && terminal, !out_valid_o || action_o == ActIgnored)

endmodule

bind request_retry_backoff_controller rrbc_checker u_rrbc_checker (.*);
